[src/sfnc_pkg.sv]
package sfnc_pkg;

    localparam int BASE_LEN_DEF = 8;
    localparam int NAME_LEN_DEF = 11;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // hand-off from the parser to the result burst
    typedef struct packed {
        logic load;
        logic err;
    } t_load;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]}) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

[src/sfnc_parser.sv]
module sfnc_parser #(
    parameter int BASE_LEN = sfnc_pkg::BASE_LEN_DEF,
    parameter int NAME_LEN = sfnc_pkg::NAME_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_ch,
    input  logic                          i_is_end,
    output sfnc_pkg::t_load               o_load,
    output logic [NAME_LEN-1:0][7:0]      o_store
);

    localparam int BASE_CAP = (BASE_LEN < NAME_LEN) ? BASE_LEN : NAME_LEN;
    localparam int CNT_W    = $clog2(NAME_LEN + 1);

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_BASE = 2'd1;
    localparam logic [1:0] PH_EXT  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]               r_phase, n_phase;
    logic [CNT_W-1:0]         r_base_cnt, n_base_cnt;
    logic [CNT_W-1:0]         r_ext_cnt, n_ext_cnt;
    logic                     r_err, n_err;
    logic [NAME_LEN-1:0][7:0] r_store;

    logic             wr_en;
    logic [CNT_W-1:0] wr_pos;
    logic [CNT_W-1:0] ext_pos;
    logic [7:0]       up_ch;

    assign up_ch   = sfnc_pkg::upcase(i_ch);
    assign ext_pos = CNT_W'(BASE_CAP) + r_ext_cnt;

    always_comb begin
        n_phase    = r_phase;
        n_base_cnt = r_base_cnt;
        n_ext_cnt  = r_ext_cnt;
        n_err      = r_err;
        wr_en      = 1'b0;
        wr_pos     = r_base_cnt;
        if (i_accept) begin
            if (i_is_end) begin
                n_phase    = PH_SKIP;
                n_base_cnt = '0;
                n_ext_cnt  = '0;
                n_err      = 1'b0;
            end else if (!r_err && r_phase != PH_DONE) begin
                if (i_ch == sfnc_pkg::CH_NUL) begin
                    if (r_phase == PH_SKIP) begin
                        n_err = 1'b1;
                    end
                    n_phase = PH_DONE;
                end else if (r_phase == PH_SKIP && i_ch == sfnc_pkg::CH_SPACE) begin
                    n_phase = PH_SKIP;
                end else if (r_phase == PH_SKIP || r_phase == PH_BASE) begin
                    n_phase = PH_BASE;
                    if (i_ch == sfnc_pkg::CH_DOT) begin
                        n_phase = PH_EXT;
                    end else if (r_base_cnt < CNT_W'(BASE_CAP)) begin
                        wr_en      = 1'b1;
                        wr_pos     = r_base_cnt;
                        n_base_cnt = r_base_cnt + 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end else begin
                    // extension; a later dot is an ordinary character
                    if (ext_pos < CNT_W'(NAME_LEN)) begin
                        wr_en     = 1'b1;
                        wr_pos    = ext_pos;
                        n_ext_cnt = r_ext_cnt + 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SKIP;
            r_base_cnt <= '0;
            r_ext_cnt  <= '0;
            r_err      <= 1'b0;
            for (int k = 0; k < NAME_LEN; k++) begin
                r_store[k] <= sfnc_pkg::CH_SPACE;
            end
        end else begin
            r_phase    <= n_phase;
            r_base_cnt <= n_base_cnt;
            r_ext_cnt  <= n_ext_cnt;
            r_err      <= n_err;
            for (int k = 0; k < NAME_LEN; k++) begin
                if (i_accept && i_is_end) begin
                    r_store[k] <= sfnc_pkg::CH_SPACE;
                end else if (wr_en && wr_pos == CNT_W'(k)) begin
                    r_store[k] <= up_ch;
                end
            end
        end
    end

    assign o_load.load = i_accept && i_is_end;
    assign o_load.err  = r_err || (r_phase == PH_SKIP);
    assign o_store     = r_store;

    a_base_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_cnt <= CNT_W'(BASE_CAP))
        else $error("base count beyond capacity");
    a_ext_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(BASE_CAP) + r_ext_cnt) <= CNT_W'(NAME_LEN))
        else $error("extension count beyond capacity");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_is_end) |=> (r_phase == PH_SKIP && !r_err
                                    && r_base_cnt == '0 && r_ext_cnt == '0))
        else $error("name state not cleared after end marker");

endmodule

[src/sfnc_burst.sv]
module sfnc_burst #(
    parameter int NAME_LEN = sfnc_pkg::NAME_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sfnc_pkg::t_load          i_load,
    input  logic [NAME_LEN-1:0][7:0] i_store,
    output logic                     o_busy,
    output logic                     o_valid,
    input  logic                     o_ready,
    output logic [7:0]               o_name_byte,
    output logic [3:0]               o_byte_index,
    output logic                     o_status,
    output logic                     o_last
);

    localparam int IDX_W = $clog2(NAME_LEN);

    logic                     r_busy;
    logic                     r_err;
    logic [IDX_W-1:0]         r_idx;
    logic [NAME_LEN-1:0][7:0] r_buf;

    logic             xfer;
    logic             at_last;
    logic [IDX_W+3:0] idx_ext;

    assign at_last = r_err || (r_idx == IDX_W'(NAME_LEN - 1));
    assign xfer    = r_busy && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_err  <= 1'b0;
            r_idx  <= '0;
        end else if (i_load.load) begin
            r_busy <= 1'b1;
            r_err  <= i_load.err;
            r_idx  <= '0;
        end else if (xfer) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // bytes leave from the bottom of a shift register
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            if (i_load.err) begin
                r_buf <= {i_store[NAME_LEN-1:1], sfnc_pkg::CH_NUL};
            end else begin
                r_buf <= i_store;
            end
        end else if (xfer) begin
            for (int k = 0; k < NAME_LEN - 1; k++) begin
                r_buf[k] <= r_buf[k+1];
            end
            r_buf[NAME_LEN-1] <= sfnc_pkg::CH_SPACE;
        end
    end

    assign idx_ext      = {4'b0000, r_idx};
    assign o_busy       = r_busy;
    assign o_valid      = r_busy;
    assign o_name_byte  = r_buf[0];
    assign o_byte_index = idx_ext[3:0];
    assign o_status     = r_err;
    assign o_last       = at_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |-> !r_busy)
        else $error("new name loaded over a burst in progress");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= IDX_W'(NAME_LEN - 1))
        else $error("byte index out of range");
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_err) |-> (r_idx == '0 && r_buf[0] == sfnc_pkg::CH_NUL))
        else $error("error result not a single zero byte");
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.load |=> (r_busy && r_idx == '0))
        else $error("burst did not start after load");

endmodule

[src/short_file_name_converter.sv]
// 8.3 short name converter. Takes one name character per cycle; only an end
// marker can be stalled, and characters after an end marker are taken while
// the previous name still drains. At the end marker the finished name moves
// to an output shift register that gives NAME_LEN results (one per cycle
// while o_ready is high), or a single error result. An end marker that
// arrives while that shift register still holds a name waits until its last
// result has been transferred and is taken in the cycle after that, so the
// burst sets the rate only for back-to-back short names.
module short_file_name_converter #(
    parameter int BASE_LEN = sfnc_pkg::BASE_LEN_DEF,
    parameter int NAME_LEN = sfnc_pkg::NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       i_ready,
    input  logic [7:0] i_ch,
    input  logic       i_is_end,
    output logic       o_valid,
    input  logic       o_ready,
    output logic [7:0] o_name_byte,
    output logic [3:0] o_byte_index,
    output logic       o_status,
    output logic       o_last
);

    sfnc_pkg::t_load          load;
    logic [NAME_LEN-1:0][7:0] store;
    logic                     busy;
    logic                     accept;

    assign i_ready = !i_is_end || !busy;
    assign accept  = i_valid && i_ready;

    sfnc_parser #(
        .BASE_LEN (BASE_LEN),
        .NAME_LEN (NAME_LEN)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_ch),
        .i_is_end (i_is_end),
        .o_load   (load),
        .o_store  (store)
    );

    sfnc_burst #(
        .NAME_LEN (NAME_LEN)
    ) u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_store      (store),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_ready      (o_ready),
        .o_name_byte  (o_name_byte),
        .o_byte_index (o_byte_index),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
